// ===== hw/rtl/idp_pkg.sv =====
`default_nettype none
package idp_pkg;

	// Parse sections.
	localparam logic [2:0] SEC_HEADER  = 3'd0;
	localparam logic [2:0] SEC_PALETTE = 3'd1;
	localparam logic [2:0] SEC_COLOR   = 3'd2;
	localparam logic [2:0] SEC_MASK    = 3'd3;
	localparam logic [2:0] SEC_DONE    = 3'd4;

	// Configuration register indexes.
	localparam logic [1:0] REG_WIDTH  = 2'd0;
	localparam logic [1:0] REG_HEIGHT = 2'd1;
	localparam logic [1:0] REG_KEY    = 2'd2;

	// Kinds of pixel write.
	localparam logic [1:0] KIND_LOOKUP = 2'd0;
	localparam logic [1:0] KIND_DIRECT = 2'd1;
	localparam logic [1:0] KIND_MASK   = 2'd2;
	localparam logic [1:0] KIND_ERROR  = 2'd3;

	localparam int HEADER_BYTES = 40;
	localparam int MAX_DIM      = 256;
	localparam int PAL_DEPTH    = 256;
	localparam int SLOTS        = 8;
	localparam logic [23:0] KEY_RESET = 24'hFF00FF;
	localparam logic [7:0]  KEY_NUDGE = 8'd36;

	// Up to eight pixel writes that one byte causes.
	typedef struct packed {
		logic [SLOTS-1:0]      mask;
		logic [1:0]            kind;
		logic [7:0]            y;
		logic [23:0]           rgb;
		logic [SLOTS-1:0][7:0] x;
		logic [SLOTS-1:0][7:0] idx;
	} job_t;

	// Palette memory write.
	typedef struct packed {
		logic        en;
		logic [7:0]  addr;
		logic [23:0] data;
	} pal_wr_t;

	// Green nudge for colors that match the key.
	function automatic logic [23:0] nudge(input logic [23:0] rgb, input logic [23:0] key);
		logic [23:0] r;
		r = rgb;
		if (rgb == key) r[15:8] = rgb[15:8] + KEY_NUDGE;
		return r;
	endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/idp_parser.sv =====
`default_nettype none
module idp_parser (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           cfg_we,
	input  wire logic [1:0]     cfg_addr,
	input  wire logic [23:0]    cfg_wdata,
	input  wire logic           accept,
	input  wire logic [7:0]     data_byte,
	input  wire logic           first_byte,
	output idp_pkg::job_t       job,
	output idp_pkg::pal_wr_t    pal_wr
);

	logic [7:0]  cfg_w_q, cfg_h_q;
	logic [23:0] key_q;
	logic [2:0]  sec_q, e_sec, n_sec;
	logic [9:0]  cnt_q, e_cnt, n_cnt;
	logic [4:0]  depth_q, n_depth;
	logic [8:0]  uw_q, uh_q, n_uw, n_uh;
	logic [7:0]  line_q, n_line;
	logic [8:0]  col_q, n_col;
	logic [1:0]  comp_q, n_comp;
	logic [23:0] part_q, n_part;
	logic [15:0] hw_q, hh_q, hd_q, e_hw, e_hh, e_hd;
	logic [10:0] cnt_inc;
	logic [9:0]  rb;
	logic [8:0]  y_full, w_sel, h_sel;
	logic [12:0] xk;
	logic        ok_depth;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_w_q <= '0;
			cfg_h_q <= '0;
			key_q   <= idp_pkg::KEY_RESET;
		end else if (cfg_we) begin
			case (cfg_addr)
				idp_pkg::REG_WIDTH:  cfg_w_q <= cfg_wdata[7:0];
				idp_pkg::REG_HEIGHT: cfg_h_q <= cfg_wdata[7:0];
				idp_pkg::REG_KEY:    key_q   <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Parse one byte: next state, palette write and the pixel job.
	always_comb begin
		e_sec = first_byte ? idp_pkg::SEC_HEADER : sec_q;
		e_cnt = first_byte ? 10'd0 : cnt_q;
		e_hw  = first_byte ? 16'd0 : hw_q;
		e_hh  = first_byte ? 16'd0 : hh_q;
		e_hd  = first_byte ? 16'd0 : hd_q;
		n_sec = e_sec; n_cnt = e_cnt; n_depth = depth_q; n_uw = uw_q; n_uh = uh_q;
		n_line = line_q; n_col = col_q; n_comp = comp_q; n_part = part_q;
		cnt_inc = {1'b0, e_cnt} + 11'd1;
		pal_wr = '0;
		job = '0;
		y_full = uh_q - 9'd1 - {1'b0, line_q};
		job.y = y_full[7:0];
		xk = '0;
		w_sel = '0; h_sel = '0; ok_depth = 1'b0;

		// Row length in bytes, padded to four.
		if (e_sec == idp_pkg::SEC_MASK) rb = (({1'b0, uw_q} + 10'd31) >> 5) << 2;
		else begin
			case (depth_q)
				5'd24:   rb = ({1'b0, uw_q} + {uw_q, 1'b0} + 10'd3) & 10'h3FC;
				5'd8:    rb = ({1'b0, uw_q} + 10'd3) & 10'h3FC;
				5'd4:    rb = (({1'b0, uw_q} + 10'd7) >> 3) << 2;
				default: rb = (({1'b0, uw_q} + 10'd31) >> 5) << 2;
			endcase
		end

		case (e_sec)
			idp_pkg::SEC_HEADER: begin
				case (e_cnt)
					10'd4:  e_hw[7:0]  = data_byte;
					10'd5:  e_hw[15:8] = data_byte;
					10'd8:  e_hh[7:0]  = data_byte;
					10'd9:  e_hh[15:8] = data_byte;
					10'd14: e_hd[7:0]  = data_byte;
					10'd15: e_hd[15:8] = data_byte;
					default: ;
				endcase
				n_cnt = cnt_inc[9:0];
				if (cnt_inc >= 11'(idp_pkg::HEADER_BYTES)) begin
					w_sel = (cfg_w_q != 8'd0) ? {1'b0, cfg_w_q} :
						(e_hw > 16'(idp_pkg::MAX_DIM)) ? 9'(idp_pkg::MAX_DIM) : e_hw[8:0];
					h_sel = (cfg_h_q != 8'd0) ? {1'b0, cfg_h_q} :
						(e_hh > 16'(idp_pkg::MAX_DIM)) ? 9'(idp_pkg::MAX_DIM) : e_hh[8:0];
					ok_depth = e_hd == 16'd1 || e_hd == 16'd4 || e_hd == 16'd8
						|| e_hd == 16'd24;
					n_uw = w_sel; n_uh = h_sel;
					n_cnt = '0; n_line = '0; n_col = '0; n_comp = '0; n_part = '0;
					if (w_sel == 9'd0 || h_sel == 9'd0 || !ok_depth) begin
						job.mask = 8'd1;
						job.kind = idp_pkg::KIND_ERROR;
						job.y = '0;
						n_sec = idp_pkg::SEC_DONE;
					end else begin
						n_depth = e_hd[4:0];
						n_sec = (e_hd == 16'd24) ? idp_pkg::SEC_COLOR : idp_pkg::SEC_PALETTE;
					end
				end
			end
			idp_pkg::SEC_PALETTE: begin
				case (e_cnt[1:0])
					2'd0: n_part = {16'd0, data_byte};
					2'd1: n_part[15:8] = data_byte;
					2'd2: n_part[23:16] = data_byte;
					default: begin
						pal_wr.en   = 1'b1;
						pal_wr.addr = e_cnt[9:2];
						pal_wr.data = idp_pkg::nudge(part_q, key_q);
						n_part = '0;
					end
				endcase
				n_cnt = cnt_inc[9:0];
				if (cnt_inc >= (11'd4 << depth_q)) begin
					n_cnt = '0;
					n_sec = idp_pkg::SEC_COLOR;
				end
			end
			idp_pkg::SEC_COLOR, idp_pkg::SEC_MASK: begin
				if (e_sec == idp_pkg::SEC_MASK) begin
					job.kind = idp_pkg::KIND_MASK;
					job.rgb = key_q;
					for (int k = 0; k < idp_pkg::SLOTS; k++) begin
						xk = {e_cnt, 3'b000} + 13'(k);
						job.x[k] = xk[7:0];
						job.mask[k] = (xk < {4'd0, uw_q}) && data_byte[7-k];
					end
				end else if (depth_q == 5'd24) begin
					job.kind = idp_pkg::KIND_DIRECT;
					if (col_q < uw_q) begin
						case (comp_q)
							2'd0: n_part[7:0] = data_byte;
							2'd1: n_part[15:8] = data_byte;
							default: begin
								job.mask = 8'd1;
								job.x[0] = col_q[7:0];
								job.rgb = idp_pkg::nudge({data_byte, part_q[15:0]}, key_q);
								n_part = '0;
								n_col = col_q + 9'd1;
							end
						endcase
						n_comp = (comp_q == 2'd2) ? 2'd0 : comp_q + 2'd1;
					end
				end else if (depth_q == 5'd8) begin
					job.mask[0] = {3'd0, e_cnt} < {4'd0, uw_q};
					job.x[0] = e_cnt[7:0];
					job.idx[0] = data_byte;
				end else if (depth_q == 5'd4) begin
					for (int k = 0; k < 2; k++) begin
						xk = {2'b00, e_cnt, 1'b0} + 13'(k);
						job.x[k] = xk[7:0];
						job.mask[k] = xk < {4'd0, uw_q};
					end
					job.idx[0] = {4'd0, data_byte[7:4]};
					job.idx[1] = {4'd0, data_byte[3:0]};
				end else begin
					for (int k = 0; k < idp_pkg::SLOTS; k++) begin
						xk = {e_cnt, 3'b000} + 13'(k);
						job.x[k] = xk[7:0];
						job.mask[k] = xk < {4'd0, uw_q};
						job.idx[k] = {7'd0, data_byte[7-k]};
					end
				end
				// Row advance.
				n_cnt = cnt_inc[9:0];
				if (cnt_inc >= {1'b0, rb}) begin
					n_cnt = '0; n_col = '0; n_part = '0; n_comp = '0;
					n_line = line_q + 8'd1;
					if ({1'b0, line_q} + 9'd1 >= uh_q) begin
						n_line = '0;
						n_sec = (e_sec == idp_pkg::SEC_COLOR) ? idp_pkg::SEC_MASK
							: idp_pkg::SEC_DONE;
					end
				end
			end
			default: ;
		endcase
		if (!accept) begin
			job.mask = '0;
			pal_wr.en = 1'b0;
		end
	end

	// Parser state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sec_q <= idp_pkg::SEC_HEADER; cnt_q <= '0; depth_q <= '0;
			uw_q <= '0; uh_q <= '0; line_q <= '0; col_q <= '0; comp_q <= '0;
			part_q <= '0; hw_q <= '0; hh_q <= '0; hd_q <= '0;
		end else if (accept) begin
			sec_q <= n_sec; cnt_q <= n_cnt; depth_q <= n_depth;
			uw_q <= n_uw; uh_q <= n_uh; line_q <= n_line; col_q <= n_col;
			comp_q <= n_comp; part_q <= n_part; hw_q <= e_hw; hh_q <= e_hh; hd_q <= e_hd;
		end
	end

endmodule
`default_nettype wire

// ===== hw/rtl/idp_emitter.sv =====
`default_nettype none
module idp_emitter (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire idp_pkg::job_t    job,
	input  wire idp_pkg::pal_wr_t pal_wr,
	output logic                  ready,
	output logic                  m_tvalid,
	input  wire logic             m_tready,
	output logic [39:0]           m_tdata,
	output logic [1:0]            m_tuser,
	output logic                  m_tlast
);

	logic [23:0] pal_mem [idp_pkg::PAL_DEPTH];
	idp_pkg::job_t job_q;
	logic [7:0]  rem, sel;
	logic [2:0]  slot;
	logic        issue, out_free, s1_adv, s1_free;
	logic        s1_v_s1, s1_last_s1;
	logic [1:0]  s1_kind_s1;
	logic [7:0]  s1_x_s1, s1_y_s1;
	logic [23:0] s1_rgb_s1, rd_s1, col;

	// Pick the lowest pending slot of the current job.
	always_comb begin
		sel  = job_q.mask & (~job_q.mask + 8'd1);
		rem  = job_q.mask & ~sel;
		slot = '0;
		for (int k = 0; k < idp_pkg::SLOTS; k++) if (sel[k]) slot = 3'(k);
	end

	assign out_free = !m_tvalid || m_tready;
	assign s1_adv   = s1_v_s1 && out_free;
	assign s1_free  = !s1_v_s1 || s1_adv;
	assign issue    = (job_q.mask != 8'd0) && s1_free;
	assign ready    = (job_q.mask == 8'd0) || (issue && rem == 8'd0);

	// Job holding register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) job_q <= '0;
		else if (ready) job_q <= job;
		else if (issue) job_q.mask <= rem;
	end

	// Palette memory, read-first on a shared address.
	always_ff @(posedge clk) begin
		if (pal_wr.en) pal_mem[pal_wr.addr] <= pal_wr.data;
		if (issue) rd_s1 <= pal_mem[job_q.idx[slot]];
	end

	// Read stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) s1_v_s1 <= 1'b0;
		else if (s1_free) s1_v_s1 <= issue;
	end
	always_ff @(posedge clk) begin
		if (issue) begin
			s1_kind_s1 <= job_q.kind; s1_x_s1 <= job_q.x[slot]; s1_y_s1 <= job_q.y;
			s1_rgb_s1 <= job_q.rgb; s1_last_s1 <= (rem == 8'd0);
		end
	end

	assign col = (s1_kind_s1 == idp_pkg::KIND_LOOKUP) ? rd_s1 : s1_rgb_s1;

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) m_tvalid <= 1'b0;
		else if (out_free) m_tvalid <= s1_v_s1;
	end
	always_ff @(posedge clk) begin
		if (s1_adv) begin
			m_tdata <= {col[7:0], col[15:8], col[23:16], s1_y_s1, s1_x_s1};
			m_tuser <= {s1_kind_s1 == idp_pkg::KIND_ERROR, s1_kind_s1 == idp_pkg::KIND_MASK};
			m_tlast <= s1_last_s1;
		end
	end

endmodule
`default_nettype wire

// ===== hw/rtl/icon_dib_pixel_decoder_core.sv =====
// Channel | Dir | Fields
// s_*     | in  | tdata: data_byte[7:0]; tuser: first_byte
// m_*     | out | tdata: pixel_x, pixel_y, red, green, blue; tuser: transparent,
//         |     | error_flag; tlast: last_of_run
// cfg_*   | in  | 0 image_width, 1 image_height, 2 key_color
// A byte is taken each cycle unless the job register still holds pixels or the output
// stalls; a byte that unpacks into up to 8 pixel writes (1-bit and mask rows) holds
// the input until all are issued, so unstalled 8 and 24 bit images take one byte per cycle.
// An accepted byte's pixels pass the job register, palette read, then output register.
// Reset clears control state; the palette memory is not cleared.
// A stall on m_tready holds the output word and backs up into the job register.
`default_nettype none
module icon_dib_pixel_decoder_core (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,   // data_byte
	input  wire logic        s_tuser,   // first_byte
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [39:0]      m_tdata,   // pixel_x, pixel_y, red, green, blue
	output logic [1:0]       m_tuser,   // transparent, error_flag
	output logic             m_tlast,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_addr,
	input  wire logic [23:0] cfg_wdata
);

	idp_pkg::job_t    job;
	idp_pkg::pal_wr_t pal_wr;
	logic             accept;

	assign accept = s_tvalid && s_tready;

	idp_parser u_parser (
		.clk, .arst_n, .cfg_we, .cfg_addr, .cfg_wdata, .accept,
		.data_byte(s_tdata), .first_byte(s_tuser), .job, .pal_wr
	);

	idp_emitter u_emitter (
		.clk, .arst_n, .job, .pal_wr, .ready(s_tready),
		.m_tvalid, .m_tready, .m_tdata, .m_tuser, .m_tlast
	);

endmodule
`default_nettype wire

// ===== hw/rtl/idp_checker.sv =====
`default_nettype none
module idp_port_checks (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [39:0] m_tdata,
	input wire logic [1:0]  m_tuser,
	input wire logic        m_tlast
);

	// A stalled word stays offered.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid) else $error("output word dropped");

	// A stalled word keeps its data.
	a_stable: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata)) else $error("output data changed");

	// The error word carries nothing else and ends its run.
	a_err: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[1] |-> m_tdata == 40'd0 && m_tlast && !m_tuser[0])
		else $error("bad error word");

	// An error word is never preceded by an unfinished run.
	a_err_alone: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && m_tuser[1] |-> $past(!(m_tvalid && !m_tlast)))
		else $error("error inside a run");

endmodule

bind icon_dib_pixel_decoder_core idp_port_checks u_idp_port_checks (
	.clk, .arst_n, .m_tvalid, .m_tready, .m_tdata, .m_tuser, .m_tlast
);
`default_nettype wire
